### src/ttb_pkg.sv
// shared types and constants for the tangent/bitangent block
`default_nettype none
package ttb_pkg;
    localparam int PosW  = 32;
    localparam int TexW  = 16;
    localparam int DposW = 33;
    localparam int DtexW = 17;
    localparam int DetW  = 35;
    localparam int NumW  = 52;
    localparam int DivW  = 49;
    localparam int QW    = 32;
    localparam int QStepW = 33;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DET,
        S_NUM,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load0;
        logic load1;
        logic start;
        logic det_step;
        logic [2:0] num_sel;
        logic num_step;
        logic div_start;
        logic div_step;
    } t_cmd;

    typedef struct packed {
        logic degenerate;
        logic div_done;
    } t_status;

    typedef struct packed {
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
        logic signed [TexW-1:0] tex_u;
        logic signed [TexW-1:0] tex_v;
    } t_corner;

    typedef struct packed {
        logic signed [QW-1:0] tangent_x;
        logic signed [QW-1:0] tangent_y;
        logic signed [QW-1:0] tangent_z;
        logic signed [QW-1:0] bitangent_x;
        logic signed [QW-1:0] bitangent_y;
        logic signed [QW-1:0] bitangent_z;
        logic                 degenerate;
    } t_result;
endpackage
`default_nettype wire

### src/ttb_if.sv
// valid/ready channel carrying one payload
`default_nettype none
interface ttb_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/ttb_ctrl.sv
// controller state machine: corner count and sequencing of the datapath
`default_nettype none
module ttb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire ttb_pkg::t_status i_status,
    output ttb_pkg::t_cmd        o_cmd
);
    import ttb_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_corner, n_corner;
    logic [2:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_corner <= 2'd0;
            r_cnt    <= 3'd0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
            r_cnt    <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_corner    = r_corner;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_corner == 2'd1) begin
                        o_cmd.load1 = 1'b1;
                        n_corner    = 2'd2;
                    end else if (r_corner == 2'd2) begin
                        o_cmd.start = 1'b1;
                        n_corner    = 2'd0;
                        n_cnt       = 3'd0;
                        n_state     = S_DET;
                    end else begin
                        o_cmd.load0 = 1'b1;
                        n_corner    = 2'd1;
                    end
                end
            end
            S_DET: begin
                // two products, one per cycle
                o_cmd.det_step = 1'b1;
                o_cmd.num_sel  = r_cnt;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd1) begin
                    n_cnt   = 3'd0;
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                if (i_status.degenerate) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.num_step = 1'b1;
                    o_cmd.num_sel  = r_cnt;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd5) begin
                        n_cnt   = 3'd0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.num_sel = r_cnt;
                if (i_status.div_done) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd6) begin
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### src/ttb_dp.sv
// datapath: held corners, shared multipliers and restoring divider
`default_nettype none
module ttb_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ttb_pkg::t_corner i_corner,
    input  wire ttb_pkg::t_cmd    i_cmd,
    output ttb_pkg::t_status      o_status,
    output ttb_pkg::t_result      o_result
);
    import ttb_pkg::*;

    logic signed [PosW-1:0]  r_p0 [3];
    logic signed [PosW-1:0]  r_p1 [3];
    logic signed [TexW-1:0]  r_u0, r_v0, r_u1, r_v1;
    logic signed [DposW-1:0] r_e1 [3];
    logic signed [DposW-1:0] r_e2 [3];
    logic signed [DtexW-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [DetW-1:0]  r_det;
    logic signed [NumW-1:0]  r_num [6];
    logic signed [QW-1:0]    r_q [6];
    logic                    r_degen;

    // divider state
    logic [DivW-1:0]   r_rem;
    logic [DivW-1:0]   r_dvd;
    logic [DetW-1:0]   r_dvs;
    logic [QStepW-1:0] r_quo;
    logic [5:0]        r_bit;
    logic              r_neg;
    logic              r_busy;
    logic [2:0]        r_idx;

    // shared multiplier operands
    logic signed [DposW-1:0] mul_a;
    logic signed [DtexW-1:0] mul_b;
    logic signed [DposW-1:0] mul_c;
    logic signed [DtexW-1:0] mul_d;
    logic signed [NumW-1:0]  prod_ab, prod_cd;

    logic signed [DposW-1:0] cur_e [3];
    logic signed [DtexW-1:0] cur_du2, cur_dv2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cur_e[i] = DposW'(i_corner.pos_x) - DposW'(r_p0[i]);
        end
        cur_e[0] = DposW'(i_corner.pos_x) - DposW'(r_p0[0]);
        cur_e[1] = DposW'(i_corner.pos_y) - DposW'(r_p0[1]);
        cur_e[2] = DposW'(i_corner.pos_z) - DposW'(r_p0[2]);
        cur_du2  = DtexW'(i_corner.tex_u) - DtexW'(r_u0);
        cur_dv2  = DtexW'(i_corner.tex_v) - DtexW'(r_v0);
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
        mul_d = '0;
        if (i_cmd.det_step) begin
            mul_a = DposW'(i_cmd.num_sel[0] ? r_dv1 : r_du1);
            mul_b = i_cmd.num_sel[0] ? r_du2 : r_dv2;
        end else begin
            case (i_cmd.num_sel) inside
                [3'd0:3'd2]: begin
                    mul_a = r_e1[i_cmd.num_sel[1:0]];
                    mul_b = r_dv2;
                    mul_c = r_e2[i_cmd.num_sel[1:0]];
                    mul_d = r_dv1;
                end
                [3'd3:3'd5]: begin
                    mul_a = r_e2[2'(i_cmd.num_sel - 3'd3)];
                    mul_b = r_du1;
                    mul_c = r_e1[2'(i_cmd.num_sel - 3'd3)];
                    mul_d = r_du2;
                end
                default: ;
            endcase
        end
        prod_ab = NumW'(mul_a) * NumW'(mul_b);
        prod_cd = NumW'(mul_c) * NumW'(mul_d);
    end

    // divider operands for the next quotient
    logic              num_neg;
    logic [NumW-1:0]   num_mag;
    logic [DetW-1:0]   det_mag;
    logic [DivW:0]     trial;
    logic [DivW-1:0]   rem_sh;

    always_comb begin
        num_neg = r_num[r_idx][NumW-1];
        num_mag = num_neg ? NumW'(-r_num[r_idx]) : NumW'(r_num[r_idx]);
        det_mag = r_det[DetW-1] ? DetW'(-r_det) : DetW'(r_det);
        rem_sh  = {r_rem[DivW-2:0], r_dvd[DivW-1]};
        trial   = {1'b0, rem_sh} - (DivW+1)'(r_dvs);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load0) begin
            r_p0[0] <= i_corner.pos_x;
            r_p0[1] <= i_corner.pos_y;
            r_p0[2] <= i_corner.pos_z;
            r_u0    <= i_corner.tex_u;
            r_v0    <= i_corner.tex_v;
        end
        if (i_cmd.load1) begin
            r_p1[0] <= i_corner.pos_x;
            r_p1[1] <= i_corner.pos_y;
            r_p1[2] <= i_corner.pos_z;
            r_u1    <= i_corner.tex_u;
            r_v1    <= i_corner.tex_v;
        end
        if (i_cmd.start) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= DposW'(r_p1[i]) - DposW'(r_p0[i]);
                r_e2[i] <= cur_e[i];
            end
            r_du1 <= DtexW'(r_u1) - DtexW'(r_u0);
            r_dv1 <= DtexW'(r_v1) - DtexW'(r_v0);
            r_du2 <= cur_du2;
            r_dv2 <= cur_dv2;
            r_det <= '0;
        end
        if (i_cmd.det_step) begin
            if (i_cmd.num_sel[0]) begin
                r_det <= r_det - DetW'(prod_ab);
            end else begin
                r_det <= DetW'(prod_ab);
            end
        end
        if (i_cmd.num_step) begin
            r_num[i_cmd.num_sel] <= prod_ab - prod_cd;
        end
        if (i_cmd.div_start) begin
            if (r_busy) begin
                // finish previous quotient with sign and clamp
                if (r_quo[QStepW-1] || r_quo[QW-1]) begin
                    r_q[r_idx - 3'd1] <= r_neg ? {1'b1, {(QW-1){1'b0}}}
                                              : {1'b0, {(QW-1){1'b1}}};
                end else begin
                    r_q[r_idx - 3'd1] <= r_neg ? QW'(-r_quo[QW-1:0])
                                              : r_quo[QW-1:0];
                end
            end
            if (r_idx != 3'd6) begin
                r_dvd <= {num_mag[DivW-15:0], 14'd0};
                r_rem <= DivW'(num_mag[NumW-1:DivW-14]);
                r_dvs <= det_mag;
                r_neg <= num_neg ^ r_det[DetW-1];
                r_quo <= '0;
                r_bit <= 6'(DivW);
            end
        end else if (i_cmd.div_step) begin
            r_rem <= trial[DivW] ? rem_sh : trial[DivW-1:0];
            r_dvd <= {r_dvd[DivW-2:0], 1'b0};
            // saturating quotient: sticky top bit
            r_quo <= {r_quo[QStepW-1] | r_quo[QStepW-2], r_quo[QStepW-3:0], ~trial[DivW]};
            r_bit <= r_bit - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= 3'd0;
            r_degen <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_busy <= 1'b0;
                r_idx  <= 3'd0;
            end else if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_idx  <= r_idx + 3'd1;
            end
            if (i_cmd.det_step && i_cmd.num_sel[0]) begin
                // second product closes the determinant
                r_degen <= (r_det == DetW'(prod_ab));
            end else if (i_cmd.start) begin
                r_degen <= 1'b0;
            end
        end
    end

    // first div_start just loads, so done is raised while idle
    assign o_status.div_done   = !r_busy || (r_bit == 6'd0);
    assign o_status.degenerate = (r_det == '0);

    assign o_result.tangent_x   = r_degen ? '0 : r_q[0];
    assign o_result.tangent_y   = r_degen ? '0 : r_q[1];
    assign o_result.tangent_z   = r_degen ? '0 : r_q[2];
    assign o_result.bitangent_x = r_degen ? '0 : r_q[3];
    assign o_result.bitangent_y = r_degen ? '0 : r_q[4];
    assign o_result.bitangent_z = r_degen ? '0 : r_q[5];
    assign o_result.degenerate  = r_degen;
endmodule
`default_nettype wire

### src/triangle_tangent_bitangent.sv
// top level: tangent and bitangent per triangle of three corners
//  channel  | dir | payload                        | rate
//  corner   | in  | pos_x/y/z Q16.16, tex_u/v Q2.14 | one per corner
//  basis    | out | tangent, bitangent, degenerate  | one per third corner
// corners one and two are only stored
// third corner: 2 determinant products and 6 numerators, then 6 quotients, each a load
// plus restoring steps on one restoring divider, and a closing store of the last one
// degenerate triangles skip numerators and divider
// synchronous active-low reset clears the corner count and controller
// no new corner is taken while a result waits or is being computed
`default_nettype none
module triangle_tangent_bitangent (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ttb_if.sink       i_corner,
    ttb_if.source     o_basis
);
    import ttb_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    deg_pend;

    ttb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_corner.valid),
        .o_in_ready (i_corner.ready),
        .o_out_valid(o_basis.valid),
        .i_out_ready(o_basis.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    t_status dp_status;
    ttb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_corner(i_corner.data),
        .i_cmd   (cmd),
        .o_status(dp_status),
        .o_result(o_basis.data)
    );

    assign deg_pend = dp_status.degenerate;
    assign status   = '{degenerate: deg_pend, div_done: dp_status.div_done};
endmodule
`default_nettype wire

### src/ttb_checker.sv
// port-level checks for the tangent block
`default_nettype none
module ttb_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_degen,
    input wire logic [31:0] out_tx
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input open while result waits");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_degen |-> out_tx == 32'd0) else $error("degenerate not zero");
    a_reset_ready: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !out_valid) else $error("valid after reset");
endmodule

bind triangle_tangent_bitangent ttb_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (i_corner.valid),
    .in_ready (i_corner.ready),
    .out_valid(o_basis.valid),
    .out_ready(o_basis.ready),
    .out_degen(o_basis.data.degenerate),
    .out_tx   (o_basis.data.tangent_x)
);
`default_nettype wire

### verif/tb_top.sv
// testbench for the per-triangle tangent and bitangent block
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import ttb_pkg::*;

    localparam int NumRandCorners = 1101;
    localparam longint CycleLimit = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    ttb_if #(.T(t_corner)) corner_if ();
    ttb_if #(.T(t_result)) basis_if ();

    triangle_tangent_bitangent DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_corner(corner_if.sink),
        .o_basis (basis_if.source)
    );

    // predictor state: corner count and the first two corners of a triangle
    logic [1:0] corner_cnt;
    t_corner    held_c0, held_c1;
    t_result    basis_queue[$];
    int         n_errors = 0;
    int         n_results = 0;
    int         n_degenerate = 0;
    int         n_saturated = 0;
    int         send_idle_pct = 37;
    int         recv_idle_pct = 72;
    longint     cycle_cnt = 0;

    // trunc(num * 2^14 / den) clamped to Q16.16
    function automatic logic signed [31:0] q_quotient(longint num, longint den);
        logic        neg;
        logic [63:0] a, b, q1, r, q;
        neg = (num < 0) != (den < 0);
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        q1 = a / b;
        r = a % b;
        if (q1 >= 64'd131072) q = 64'h1_0000_0000;
        else q = (q1 << 14) + ((r << 14) / b);
        if (neg) begin
            if (q >= 64'h8000_0000) begin
                n_saturated++;
                return 32'sh8000_0000;
            end
            return -$signed(q[31:0]);
        end
        if (q > 64'h7fff_ffff) begin
            n_saturated++;
            return 32'sh7fff_ffff;
        end
        return q[31:0];
    endfunction

    function automatic t_result tangent_basis(t_corner c2);
        t_result res;
        longint  e1[3], e2[3], du1, dv1, du2, dv2, det;
        e1[0] = longint'(held_c1.pos_x) - longint'(held_c0.pos_x);
        e1[1] = longint'(held_c1.pos_y) - longint'(held_c0.pos_y);
        e1[2] = longint'(held_c1.pos_z) - longint'(held_c0.pos_z);
        e2[0] = longint'(c2.pos_x) - longint'(held_c0.pos_x);
        e2[1] = longint'(c2.pos_y) - longint'(held_c0.pos_y);
        e2[2] = longint'(c2.pos_z) - longint'(held_c0.pos_z);
        du1 = longint'(held_c1.tex_u) - longint'(held_c0.tex_u);
        dv1 = longint'(held_c1.tex_v) - longint'(held_c0.tex_v);
        du2 = longint'(c2.tex_u) - longint'(held_c0.tex_u);
        dv2 = longint'(c2.tex_v) - longint'(held_c0.tex_v);
        det = du1 * dv2 - dv1 * du2;
        res = '0;
        if (det == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        res.tangent_x   = q_quotient(e1[0] * dv2 - e2[0] * dv1, det);
        res.tangent_y   = q_quotient(e1[1] * dv2 - e2[1] * dv1, det);
        res.tangent_z   = q_quotient(e1[2] * dv2 - e2[2] * dv1, det);
        res.bitangent_x = q_quotient(e2[0] * du1 - e1[0] * du2, det);
        res.bitangent_y = q_quotient(e2[1] * du1 - e1[1] * du2, det);
        res.bitangent_z = q_quotient(e2[2] * du1 - e1[2] * du2, det);
        return res;
    endfunction

    function automatic void predict_corner(t_corner c);
        if (corner_cnt == 2'd1) begin
            held_c1 = c;
            corner_cnt = 2'd2;
        end else if (corner_cnt == 2'd2) begin
            basis_queue = {basis_queue, tangent_basis(c)};
            corner_cnt = 2'd0;
        end else begin
            held_c0 = c;
            corner_cnt = 2'd1;
        end
    endfunction

    // corner and optionally a typed-in expectation checked directly
    typedef struct {
        t_corner c;
        logic    has_fixed;
        t_result fixed;
    } t_row;
    t_row    directed_rows[$];
    t_result fixed_queue[$];
    logic    fixed_flag_queue[$];

    function automatic t_corner mk(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z, logic signed [15:0] u,
                                   logic signed [15:0] v);
        t_corner c;
        c.pos_x = x; c.pos_y = y; c.pos_z = z; c.tex_u = u; c.tex_v = v;
        return c;
    endfunction

    function automatic void add_row(t_corner c, logic has_fixed, t_result f);
        t_row r;
        r.c = c; r.has_fixed = has_fixed; r.fixed = f;
        directed_rows = {directed_rows, r};
    endfunction

    function automatic t_corner rand_corner(int mode);
        t_corner c;
        c.pos_x = $urandom; c.pos_y = $urandom; c.pos_z = $urandom;
        c.tex_u = 16'($urandom); c.tex_v = 16'($urandom);
        if (mode == 1) begin
            // small positions and uv keep quotients mostly in range
            c.pos_x = $signed(32'($urandom_range(0, 20'hfffff))) - 32'sh80000;
            c.pos_y = $signed(32'($urandom_range(0, 20'hfffff))) - 32'sh80000;
            c.pos_z = $signed(32'($urandom_range(0, 20'hfffff))) - 32'sh80000;
            c.tex_u = $signed(16'($urandom_range(0, 16'h3fff))) - 16'sh2000;
            c.tex_v = $signed(16'($urandom_range(0, 16'h3fff))) - 16'sh2000;
        end else if (mode == 2) begin
            c.tex_u = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            c.tex_v = 16'($urandom_range(0, 3)) - 16'd2;
        end
        return c;
    endfunction

    // valid stays high between back-to-back corners and drops only to idle
    task automatic send_corner(t_corner c);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            corner_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        corner_if.valid <= 1'b1;
        corner_if.data  <= c;
        @(posedge i_clk);
        while (!corner_if.ready) @(posedge i_clk);
        predict_corner(c);
    endtask

    // receiver: random stalls, compares each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r, act;
        logic    has_f;
        if (!i_rst_n) begin
            basis_if.ready <= 1'b0;
        end else begin
            if (basis_if.valid && basis_if.ready) begin
                act = basis_if.data;
                if (basis_queue.size() == 0) begin
                    $error("basis transfer with no expectation waiting");
                    n_errors++;
                end else begin
                    exp_r = basis_queue.pop_front();
                    has_f = fixed_flag_queue.size() ? fixed_flag_queue.pop_front() : 1'b0;
                    if (has_f) begin
                        if (fixed_queue.pop_front() !== exp_r) begin
                            $error("predictor disagrees with typed-in row");
                            n_errors++;
                        end
                    end
                    n_results++;
                    if (exp_r.degenerate) n_degenerate++;
                    if (act.tangent_x !== exp_r.tangent_x) begin
                        $error("tangent_x exp %0d got %0d", exp_r.tangent_x, act.tangent_x);
                        n_errors++;
                    end
                    if (act.tangent_y !== exp_r.tangent_y) begin
                        $error("tangent_y exp %0d got %0d", exp_r.tangent_y, act.tangent_y);
                        n_errors++;
                    end
                    if (act.tangent_z !== exp_r.tangent_z) begin
                        $error("tangent_z exp %0d got %0d", exp_r.tangent_z, act.tangent_z);
                        n_errors++;
                    end
                    if (act.bitangent_x !== exp_r.bitangent_x) begin
                        $error("bitangent_x exp %0d got %0d", exp_r.bitangent_x,
                               act.bitangent_x);
                        n_errors++;
                    end
                    if (act.bitangent_y !== exp_r.bitangent_y) begin
                        $error("bitangent_y exp %0d got %0d", exp_r.bitangent_y,
                               act.bitangent_y);
                        n_errors++;
                    end
                    if (act.bitangent_z !== exp_r.bitangent_z) begin
                        $error("bitangent_z exp %0d got %0d", exp_r.bitangent_z,
                               act.bitangent_z);
                        n_errors++;
                    end
                    if (act.degenerate !== exp_r.degenerate) begin
                        $error("degenerate exp %0b got %0b", exp_r.degenerate,
                               act.degenerate);
                        n_errors++;
                    end
                end
            end
            basis_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_result z, f;
        int      mode;
        z = '0;
        corner_cnt = 2'd0;
        held_c0 = '0;
        held_c1 = '0;
        corner_if.valid = 1'b0;
        corner_if.data  = '0;
        basis_if.ready  = 1'b0;

        // degenerate: identical uv on all corners, extreme positions
        f = '0; f.degenerate = 1'b1;
        add_row(mk(32'sh7fffffff, 32'sh80000000, 0, 16'sh7fff, 16'sh8000), 0, z);
        add_row(mk(32'sh80000000, 32'sh7fffffff, -1, 16'sh7fff, 16'sh8000), 0, z);
        add_row(mk(0, 0, 32'sh7fffffff, 16'sh7fff, 16'sh8000), 1, f);
        // unit square uv, unit edges: tangent (1,0,0), bitangent (0,1,0)
        f = '0; f.tangent_x = 32'sh10000; f.bitangent_y = 32'sh10000;
        add_row(mk(0, 0, 0, 0, 0), 0, z);
        add_row(mk(32'sh10000, 0, 0, 16'sh4000, 0), 0, z);
        add_row(mk(0, 32'sh10000, 0, 0, 16'sh4000), 1, f);
        // saturation: huge edges over a tiny determinant
        add_row(mk(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, 0), 0, z);
        add_row(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1, 0), 0, z);
        add_row(mk(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 1), 0, z);
        // extreme uv deltas in both signs
        add_row(mk(-1, -1, -1, 16'sh8000, 16'sh7fff), 0, z);
        add_row(mk(32'sh12345678, -5, 7, 16'sh7fff, 16'sh8000), 0, z);
        add_row(mk(3, 32'shfedcba98, 9, 16'sh8000, 16'sh8000), 0, z);
        // collinear uv, nonzero deltas
        f = '0; f.degenerate = 1'b1;
        add_row(mk(1, 2, 3, 16'sh0100, 16'sh0100), 0, z);
        add_row(mk(4, 5, 6, 16'sh0200, 16'sh0200), 0, z);
        add_row(mk(7, 8, 9, 16'sh0300, 16'sh0300), 1, f);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].has_fixed) begin
                fixed_flag_queue = {fixed_flag_queue, 1'b1};
                fixed_queue = {fixed_queue, directed_rows[i].fixed};
            end else if ((i % 3) == 2) begin
                fixed_flag_queue = {fixed_flag_queue, 1'b0};
            end
            send_corner(directed_rows[i].c);
        end

        for (int i = 0; i < NumRandCorners; i++) begin
            if (i == NumRandCorners / 3) begin
                send_idle_pct = 72; recv_idle_pct = 37;
            end else if (i == 2 * NumRandCorners / 3) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            // one mode per triangle
            if (corner_cnt == 2'd0) mode = $urandom_range(0, 9) < 6 ? 1 :
                                           ($urandom_range(0, 3) == 0 ? 2 : 0);
            send_corner(rand_corner(mode));
        end
        corner_if.valid <= 1'b0;

        while (basis_queue.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("%0d triangles checked, %0d degenerate, %0d saturated components",
                 n_results, n_degenerate, n_saturated);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
src/ttb_pkg.sv
src/ttb_if.sv
src/ttb_ctrl.sv
src/ttb_dp.sv
src/triangle_tangent_bitangent.sv
src/ttb_checker.sv
verif/tb_top.sv
